// File: rtl/uft_pkg.sv
`default_nettype none
package uft_pkg;

	// default table size and register reset value
	localparam int unsigned TABLE_ENTRIES_DEF = 64;
	localparam logic [15:0] TIMEOUT_RESET     = 16'd30;

	// packet classes
	localparam logic [1:0] CLASS_DESTINATION = 2'd0;
	localparam logic [1:0] CLASS_SERVICE     = 2'd1;
	localparam logic [1:0] CLASS_STREAM      = 2'd2;

	// commands from controller to datapath
	typedef struct packed {
		logic load;    // latch the incoming item, clear search state
		logic rd_en;   // read one slot from the table memories
		logic update;  // write back the outcome, register the result
	} uft_cmd_t;

endpackage
`default_nettype wire

// File: rtl/udp_flow_tracker.sv
// UDP flow tracker: a table of flows scanned one slot per cycle from slot 0.
// done follows the scan of every slot, the drain state and the write-back state.
// One item at a time: a new start is taken in the done cycle, and no new item is
// taken while busy. The receiver cannot stall: done lasts one cycle, while
// packet_class and table_full hold until the next write-back. Reset clears all
// slot valid and reply marks and sets the timeout register timeout_q to 30.
`default_nettype none
module udp_flow_tracker
	import uft_pkg::*;
#(
	parameter int unsigned TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [31:0] src_addr,
	input  wire logic [31:0] dst_addr,
	input  wire logic [15:0] src_port,
	input  wire logic [15:0] dst_port,
	input  wire logic [31:0] now_seconds,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [15:0] cfg_data,
	output logic             done,
	output logic      [1:0]  packet_class,
	output logic             table_full
);

	localparam int unsigned AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

	uft_cmd_t      cmd;
	logic [AW-1:0] rd_addr;

	// register writes are always taken
	assign cfg_ready = 1'b1;

	uft_ctrl #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.done    (done),
		.cmd     (cmd),
		.rd_addr (rd_addr)
	);

	uft_dp #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.rd_addr      (rd_addr),
		.cfg_wr       (cfg_valid && cfg_ready),
		.cfg_data     (cfg_data),
		.src_addr     (src_addr),
		.dst_addr     (dst_addr),
		.src_port     (src_port),
		.dst_port     (dst_port),
		.now_seconds  (now_seconds),
		.packet_class (packet_class),
		.table_full   (table_full)
	);

endmodule
`default_nettype wire

// File: rtl/uft_ram.sv
`default_nettype none
module uft_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 64
) (
	input  wire logic                                     clk,
	input  wire logic                                     we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                         wdata,
	input  wire logic                                     re,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

// File: rtl/uft_ctrl.sv
`default_nettype none
module uft_ctrl
	import uft_pkg::*;
#(
	parameter int unsigned TABLE_ENTRIES = TABLE_ENTRIES_DEF,
	localparam int unsigned AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	output logic               busy,
	output logic               done,
	output uft_cmd_t           cmd,
	output logic      [AW-1:0] rd_addr
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_UPDATE
	} state_t;

	localparam logic [AW-1:0] LAST_ADDR = AW'(TABLE_ENTRIES - 1);

	state_t        state_q;
	logic [AW-1:0] addr_q;
	logic          done_q;

	// commands decoded from state
	assign busy       = (state_q != ST_IDLE);
	assign cmd.load   = start && (state_q == ST_IDLE);
	assign cmd.rd_en  = (state_q == ST_SCAN);
	assign cmd.update = (state_q == ST_UPDATE);
	assign rd_addr    = addr_q;
	assign done       = done_q;

	// sequencer: scan every slot, let the last compare drain, then write back
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			addr_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			// result strobe follows the write-back cycle
			done_q <= (state_q == ST_UPDATE);
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						addr_q  <= '0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (addr_q == LAST_ADDR) begin
						state_q <= ST_DRAIN;
					end else begin
						addr_q <= addr_q + AW'(1);
					end
				end
				ST_DRAIN: begin
					state_q <= ST_UPDATE;
				end
				ST_UPDATE: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

// File: rtl/uft_dp.sv
`default_nettype none
module uft_dp
	import uft_pkg::*;
#(
	parameter int unsigned TABLE_ENTRIES = TABLE_ENTRIES_DEF,
	localparam int unsigned AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire uft_cmd_t      cmd,
	input  wire logic [AW-1:0] rd_addr,
	input  wire logic          cfg_wr,
	input  wire logic [15:0]   cfg_data,
	input  wire logic [31:0]   src_addr,
	input  wire logic [31:0]   dst_addr,
	input  wire logic [15:0]   src_port,
	input  wire logic [15:0]   dst_port,
	input  wire logic [31:0]   now_seconds,
	output logic      [1:0]    packet_class,
	output logic               table_full
);

	localparam int unsigned TW = 96;

	// configuration
	logic [15:0] timeout_q;

	// latched item
	logic [31:0] sa_q, da_q, now_q;
	logic [15:0] sp_q, dp_q;

	// per-slot flags
	logic [TABLE_ENTRIES-1:0] valid_q;
	logic [TABLE_ENTRIES-1:0] reply_q;

	// search state
	logic          hit_q;
	logic [AW-1:0] hit_idx_q;
	logic [1:0]    hit_class_q;
	logic          free_found_q;
	logic [AW-1:0] free_idx_q;

	// compare stage, aligned with the registered memory read
	logic          cmp_vld_s1;
	logic [AW-1:0] cmp_idx_s1;

	// result
	logic [1:0] class_q;
	logic       full_q;

	// memory ports
	logic [TW-1:0] tuple_rd, tuple_wr, tuple_rev;
	logic [31:0]   time_rd;
	logic          tuple_we, time_we;
	logic [AW-1:0] wr_addr;

	// compare terms
	logic        slot_v, expired, exact, reverse, cmp_live;
	logic [31:0] age;

	assign tuple_wr  = {sa_q, da_q, sp_q, dp_q};
	assign tuple_rev = {da_q, sa_q, dp_q, sp_q};
	assign wr_addr   = hit_q ? hit_idx_q : free_idx_q;
	assign time_we   = cmd.update && (hit_q || free_found_q);
	assign tuple_we  = cmd.update && !hit_q && free_found_q;

	uft_ram #(.WIDTH(TW), .DEPTH(TABLE_ENTRIES)) u_tuple_ram (
		.clk   (clk),
		.we    (tuple_we),
		.waddr (wr_addr),
		.wdata (tuple_wr),
		.re    (cmd.rd_en),
		.raddr (rd_addr),
		.rdata (tuple_rd)
	);

	uft_ram #(.WIDTH(32), .DEPTH(TABLE_ENTRIES)) u_time_ram (
		.clk   (clk),
		.we    (time_we),
		.waddr (wr_addr),
		.wdata (now_q),
		.re    (cmd.rd_en),
		.raddr (rd_addr),
		.rdata (time_rd)
	);

	// slot checks: age against timeout, tuple in both directions
	always_comb begin
		slot_v   = valid_q[cmp_idx_s1];
		age      = now_q - time_rd;
		expired  = age > {16'b0, timeout_q};
		exact    = (tuple_rd == tuple_wr);
		reverse  = (tuple_rd == tuple_rev);
		cmp_live = cmp_vld_s1 && !hit_q;
	end

	// config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RESET;
		end else if (cfg_wr) begin
			timeout_q <= cfg_data;
		end
	end

	// item latch, compare index, search records and result registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			sa_q  <= src_addr;
			da_q  <= dst_addr;
			sp_q  <= src_port;
			dp_q  <= dst_port;
			now_q <= now_seconds;
		end
		if (cmd.update) begin
			class_q <= hit_q ? hit_class_q : CLASS_DESTINATION;
			full_q  <= !hit_q && !free_found_q;
		end
		if (cmd.rd_en) begin
			cmp_idx_s1 <= rd_addr;
		end
		if (cmp_live && slot_v && !expired && (exact || reverse)) begin
			hit_idx_q <= cmp_idx_s1;
			hit_class_q <= (exact || reply_q[cmp_idx_s1]) ? CLASS_STREAM : CLASS_SERVICE;
		end
		if (cmp_live && !free_found_q && (!slot_v || expired)) begin
			free_idx_q <= cmp_idx_s1;
		end
	end

	// scan control and slot flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q      <= '0;
			reply_q      <= '0;
			hit_q        <= 1'b0;
			free_found_q <= 1'b0;
			cmp_vld_s1   <= 1'b0;
		end else begin
			cmp_vld_s1 <= cmd.rd_en;
			if (cmd.load) begin
				hit_q        <= 1'b0;
				free_found_q <= 1'b0;
			end
			if (cmp_live) begin
				if (!slot_v || expired) begin
					// free slot: retire an expired flow, remember the lowest
					valid_q[cmp_idx_s1] <= 1'b0;
					reply_q[cmp_idx_s1] <= 1'b0;
					free_found_q        <= 1'b1;
				end else if (exact) begin
					hit_q <= 1'b1;
				end else if (reverse) begin
					hit_q               <= 1'b1;
					reply_q[cmp_idx_s1] <= 1'b1;
				end
			end
			// new flow goes into the lowest free slot
			if (cmd.update && !hit_q && free_found_q) begin
				valid_q[free_idx_q] <= 1'b1;
				reply_q[free_idx_q] <= 1'b0;
			end
		end
	end

	assign packet_class = class_q;
	assign table_full   = full_q;

endmodule
`default_nettype wire
